// ----- rtl/u2u_pkg.sv -----
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
package u2u_pkg;

    localparam int unsigned UNIT_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PADDR_W    = 3;

    // Register byte addresses, decoded on paddr[2].
    localparam logic REG_MAX_UNITS = 1'b0;

    localparam logic [UNIT_W-1:0] MAX_UNITS_RESET = 16'd255;

    // Byte classification masks and patterns.
    localparam logic [BYTE_W-1:0] ASCII_MAX   = 8'h7F;
    localparam logic [BYTE_W-1:0] MASK_TOP2   = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_TOP3   = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_TOP4   = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_CONT    = 8'h80;
    localparam logic [BYTE_W-1:0] PAT_LEAD2   = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3   = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_BITS6  = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_BITS5  = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_BITS4  = 8'h0F;

    typedef struct packed {
        logic              malformed;
        logic              terminator;
        logic [UNIT_W-1:0] code_unit;
    } result_t;

    // Up to two results per accepted byte, written in order r0 then r1.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ----- rtl/u2u_front.sv -----
// Front part: per-byte sequence tracking and result generation.
module u2u_front #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [u2u_pkg::UNIT_W-1:0]   max_units,
    input  logic                         take,
    input  logic [u2u_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         last_byte,
    output u2u_pkg::push_t               push
);
    import u2u_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > UNIT_W) ? COUNT_WIDTH : UNIT_W;

    logic [1:0]             pending_reg, pending_next;
    logic [UNIT_W-1:0]      partial_reg, partial_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;
    logic                   full_reg, full_next;
    logic                   disc_reg, disc_next;

    logic [1:0]        pend_dec;
    logic [UNIT_W-1:0] cont_bits;
    logic              emit_unit;
    logic [UNIT_W-1:0] unit_val;
    logic              err;
    logic              limit_hit;
    logic [COUNT_WIDTH-1:0] units_inc;
    result_t           unit_res;
    result_t           term_res;

    assign limit_hit = CMP_W'(units_reg) >= CMP_W'(max_units);
    assign units_inc = (&units_reg) ? units_reg : units_reg + COUNT_WIDTH'(1);
    assign pend_dec  = pending_reg - 2'd1;
    assign cont_bits = (pend_dec == 2'd1) ? {2'b0, in_byte & MASK_BITS6, 6'b0}
                                          : {8'b0, in_byte & MASK_BITS6};

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        units_next   = units_reg;
        full_next    = full_reg;
        disc_next    = disc_reg;
        emit_unit    = 1'b0;
        unit_val     = '0;
        err          = 1'b0;

        if (disc_reg || full_reg)
        begin
            // Byte ignored.
        end
        else if (pending_reg != 2'd0)
        begin
            if ((in_byte & MASK_TOP2) != PAT_CONT)
            begin
                err = 1'b1;
            end
            else
            begin
                pending_next = pend_dec;
                partial_next = partial_reg | cont_bits;
                if (pend_dec == 2'd0)
                begin
                    emit_unit    = 1'b1;
                    unit_val     = partial_reg | cont_bits;
                    units_next   = units_inc;
                    partial_next = '0;
                end
                else if (last_byte)
                begin
                    err = 1'b1;
                end
            end
        end
        else if (limit_hit)
        begin
            full_next = 1'b1;
        end
        else if (in_byte <= ASCII_MAX)
        begin
            emit_unit  = 1'b1;
            unit_val   = {8'b0, in_byte};
            units_next = units_inc;
        end
        else if ((in_byte & MASK_TOP3) == PAT_LEAD2)
        begin
            partial_next = {5'b0, in_byte[4:0] & MASK_BITS5[4:0], 6'b0};
            pending_next = 2'd1;
            err          = last_byte;
        end
        else if ((in_byte & MASK_TOP4) == PAT_LEAD3)
        begin
            partial_next = {in_byte[3:0] & MASK_BITS4[3:0], 12'b0};
            pending_next = 2'd2;
            err          = last_byte;
        end
        else
        begin
            err = 1'b1;
        end

        if (err || last_byte)
        begin
            pending_next = 2'd0;
            partial_next = '0;
            units_next   = '0;
            full_next    = 1'b0;
            disc_next    = err && !last_byte;
        end
    end

    always_comb
    begin
        unit_res = '{malformed: 1'b0, terminator: 1'b0, code_unit: unit_val};
        term_res = '{malformed: err, terminator: 1'b1, code_unit: '0};
        push.r0  = unit_res;
        push.r1  = term_res;
        push.cnt = 2'd0;
        if (take)
        begin
            if (emit_unit)
            begin
                push.cnt = (last_byte || err) ? 2'd2 : 2'd1;
            end
            else if (err || (last_byte && !disc_reg))
            begin
                push.r0  = term_res;
                push.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            units_reg   <= '0;
            full_reg    <= 1'b0;
            disc_reg    <= 1'b0;
        end
        else if (take)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            units_reg   <= units_next;
            full_reg    <= full_next;
            disc_reg    <= disc_next;
        end
    end

    // A string waiting on continuation bytes is never past its unit limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(full_reg && pending_reg != 2'd0))
        else $error("front: output_full while a sequence is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(full_reg && disc_reg))
        else $error("front: discarding and output_full both set");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> pending_reg == 2'd0 && units_reg == '0 && !full_reg && !disc_reg)
        else $error("front: string state not cleared after final byte");

endmodule

// ----- rtl/u2u_queue.sv -----
// Result queue between front and back: two writes and one read per cycle.
module u2u_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  u2u_pkg::push_t   push,
    input  logic             pop,
    output logic             has_room,
    output logic             not_empty,
    output u2u_pkg::result_t head
);
    import u2u_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wp_reg;
    logic [QPTR_W-1:0]   rp_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wp_1;

    assign wp_1      = wp_reg + QPTR_W'(1);
    assign not_empty = count_reg != '0;
    assign has_room  = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wp_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wp_1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + QPTR_W'(push.cnt);
            rp_reg    <= rp_reg + QPTR_W'(pop);
            count_reg <= count_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue: occupancy beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue: read from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> has_room)
        else $error("queue: write without room");

endmodule

// ----- rtl/u2u_back.sv -----
// Back part: output register that presents results on the master stream.
module u2u_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  u2u_pkg::result_t            q_head,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [u2u_pkg::UNIT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser
);
    import u2u_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign q_pop = q_valid && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_axis_tready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_head;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg.code_unit;
    assign m_axis_tlast  = data_reg.terminator;
    assign m_axis_tuser  = data_reg.malformed;

endmodule

// ----- rtl/utf8_to_ucs2_stream_decoder_core.sv -----
// UTF-8 to UCS-2 stream decoder: top level with APB register and stream ports.
//
// Bytes enter on the slave stream (tlast marks the final byte of a string) and
// 16-bit code units leave on the master stream, each string closed by a word with
// tlast set, tuser flagging a malformed or truncated string. The decoder takes one
// byte per cycle, and results go into a four-entry queue ahead of the output
// register. A final byte that completes a unit produces two words, which drain at
// one word per cycle while the output is ready; the input stalls only while the
// queue has fewer than two free entries. No clearing pass follows reset. max_units
// lives at byte address 0 and should be written while idle.
module utf8_to_ucs2_stream_decoder_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u2u_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input bytes
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
    input  logic                          s_axis_tlast,
    // Output words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,  // [15:0] code_unit
    output logic                          m_axis_tlast,
    output logic                          m_axis_tuser   // [0] malformed
);
    import u2u_pkg::*;

    logic [UNIT_W-1:0] max_units_reg;
    logic              take;
    logic              has_room;
    logic              q_valid;
    logic              q_pop;
    push_t             push;
    result_t           q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_UNITS) ? {16'b0, max_units_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= MAX_UNITS_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_MAX_UNITS)
        begin
            max_units_reg <= pwdata[UNIT_W-1:0];
        end
    end

    assign s_axis_tready = has_room;
    assign take          = s_axis_tvalid && has_room;

    u2u_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_units (max_units_reg),
        .take      (take),
        .in_byte   (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push)
    );

    u2u_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (q_pop),
        .has_room  (has_room),
        .not_empty (q_valid),
        .head      (q_head)
    );

    u2u_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Only a terminator word may carry the malformed flag, and it carries no unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("core: malformed flag on a unit word");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 16'd0)
        else $error("core: terminator word carries a code unit");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("core: stalled output word changed");

endmodule

// ----- tb/sv/tb_utf8_to_ucs2_stream_decoder_core.sv -----
// Self-checking testbench for the UTF-8 to UCS-2 stream decoder core.
module tb_utf8_to_ucs2_stream_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import u2u_pkg::*;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [PADDR_W-1:0] MAX_UNITS_ADDR = {REG_MAX_UNITS, 2'b00};

    localparam result_t NO_WORD  = '{malformed: 1'b0, terminator: 1'b0, code_unit: 16'h0000};
    localparam result_t TERM_OK  = '{malformed: 1'b0, terminator: 1'b1, code_unit: 16'h0000};
    localparam result_t TERM_BAD = '{malformed: 1'b1, terminator: 1'b1, code_unit: 16'h0000};

    typedef enum logic [1:0] {
        ROW_SET_LIMIT,
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] val;
        logic        last;
        int          n;
        result_t     w0;
        result_t     w1;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    utf8_to_ucs2_stream_decoder_core #(
        .COUNT_WIDTH(CNT_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Decoder state mirrored by the predictor.
    logic [1:0]       seq_left = '0;
    logic [15:0]      unit_acc = '0;
    logic [CNT_W-1:0] unit_count = '0;
    bit               str_full = 1'b0;
    bit               str_drop = 1'b0;
    logic [15:0]      unit_cap = MAX_UNITS_RESET;

    result_t  units_due[$];
    dir_row_t dir_rows[$];

    int  fail_count = 0;
    int  bytes_taken = 0;
    int  bytes_sent = 0;
    int  words_seen = 0;
    int  strings_seen = 0;
    int  bad_strings = 0;
    int  cap_writes = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;
    bit  start_hold = 1'b0;
    bit  hold_done = 1'b0;

    function automatic result_t unit_word(input logic [15:0] u);
        result_t w;
        w = NO_WORD;
        w.code_unit = u;
        return w;
    endfunction

    function automatic dir_row_t mk_row(input row_kind_t k, input logic [15:0] v,
                                        input logic l, input int n,
                                        input result_t w0, input result_t w1);
        dir_row_t r;
        r.kind = k;
        r.val  = v;
        r.last = l;
        r.n    = n;
        r.w0   = w0;
        r.w1   = w1;
        return r;
    endfunction

    function automatic void clear_string_state();
        seq_left   = '0;
        unit_acc   = '0;
        unit_count = '0;
        str_full   = 1'b0;
        str_drop   = 1'b0;
    endfunction

    // Works out the words that one accepted byte produces and advances the state.
    function automatic void predict_units(input logic [7:0] b, input logic last,
                                          output int n, output result_t w0,
                                          output result_t w1, output bit counted);
        result_t outw[2];
        bit      err;
        n       = 0;
        err     = 1'b0;
        outw[0] = NO_WORD;
        outw[1] = NO_WORD;
        counted = !(str_drop || str_full);
        if (str_drop || str_full) begin
        end else if (seq_left != 0) begin
            if ((b & MASK_TOP2) != PAT_CONT) begin
                err = 1'b1;
            end else begin
                seq_left = seq_left - 2'd1;
                unit_acc = unit_acc | (16'(b & MASK_BITS6) << (6 * seq_left));
                if (seq_left == 0) begin
                    outw[n] = unit_word(unit_acc);
                    n++;
                    if (unit_count != '1)
                        unit_count++;
                    unit_acc = '0;
                end else if (last) begin
                    err = 1'b1;
                end
            end
        end else if (CNT_W'(unit_count) >= CNT_W'(unit_cap)) begin
            str_full = 1'b1;
        end else if (b <= ASCII_MAX) begin
            outw[n] = unit_word({8'h00, b});
            n++;
            if (unit_count != '1)
                unit_count++;
        end else if ((b & MASK_TOP3) == PAT_LEAD2) begin
            unit_acc = 16'(b & MASK_BITS5) << 6;
            seq_left = 2'd1;
            if (last)
                err = 1'b1;
        end else if ((b & MASK_TOP4) == PAT_LEAD3) begin
            unit_acc = 16'(b & MASK_BITS4) << 12;
            seq_left = 2'd2;
            if (last)
                err = 1'b1;
        end else begin
            err = 1'b1;
        end

        if (err) begin
            outw[n] = TERM_BAD;
            n++;
            clear_string_state();
            if (!last)
                str_drop = 1'b1;
        end else if (last) begin
            if (!str_drop) begin
                outw[n] = TERM_OK;
                n++;
            end
            clear_string_state();
        end
        w0 = outw[0];
        w1 = outw[1];
    endfunction

    // Offers one byte, waits for the handshake, then queues what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input int tn, input result_t t0, input result_t t1);
        int      pn;
        result_t p0;
        result_t p1;
        bit      counted;
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_units(b, last, pn, p0, p1, counted);
        if (typed) begin
            pn = tn;
            p0 = t0;
            p1 = t1;
        end
        if (pn > 0)
            units_due.push_back(p0);
        if (pn > 1)
            units_due.push_back(p1);
        bytes_sent++;
        if (counted)
            bytes_taken++;
        @(negedge clk);
    endtask

    task automatic write_cap(input logic [15:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_UNITS_ADDR;
        pwdata  <= {16'h0000, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Back-to-back read of the same register; psel stays high.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== v) begin
            $error("max_units readback: expected %0d, got %0d", v, prdata[15:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lets the decoder drain completely before the limit register changes.
    task automatic set_limit(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (units_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_cap(v);
        unit_cap = v;
        cap_writes++;
    endtask

    // Sends one string: mostly valid UTF-8, sometimes cut short, corrupted or pure noise.
    task automatic send_string();
        logic [7:0] sbuf[$];
        int         nch;
        int         pick;
        int         shape;
        int         i;
        shape = $urandom_range(0, 99);
        nch = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (i = 0; i < nch; i++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                sbuf.push_back(8'($urandom_range(0, 127)));
            end else if (pick == 1) begin
                sbuf.push_back(PAT_LEAD2 | 8'($urandom_range(0, 31)));
                sbuf.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
            end else begin
                sbuf.push_back(PAT_LEAD3 | 8'($urandom_range(0, 15)));
                sbuf.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
                sbuf.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
            end
        end
        if (shape >= 80 && shape < 88) begin
            // End the string in the middle of a sequence.
            if ($urandom_range(0, 1) == 0) begin
                sbuf.push_back(PAT_LEAD2 | 8'($urandom_range(0, 31)));
            end else begin
                sbuf.push_back(PAT_LEAD3 | 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 1) == 0)
                    sbuf.push_back(PAT_CONT | 8'($urandom_range(0, 63)));
            end
        end else if (shape >= 88 && shape < 95) begin
            sbuf[$urandom_range(0, sbuf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (shape >= 95) begin
            sbuf.delete();
            repeat ($urandom_range(1, 6)) sbuf.push_back(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < sbuf.size(); i++)
            send_byte(sbuf[i], i == sbuf.size() - 1, 1'b0, 0, NO_WORD, NO_WORD);
    endtask

    task automatic run_phase(input logic [15:0] cap, input int target, input bit pressure,
                             input bit no_gaps);
        int start_count;
        set_limit(cap);
        steady = no_gaps;
        if (pressure)
            start_hold = 1'b1;
        start_count = bytes_sent;
        while (bytes_sent - start_count < target)
            send_string();
        steady = 1'b0;
    endtask

    // Output ready: random stalls, one long hold-off on request, none while steady.
    always @(negedge clk) begin
        if (start_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
        end
    end

    // Output checker and watchdog.
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                if (m_axis_tlast)
                    strings_seen++;
                if (m_axis_tlast && m_axis_tuser)
                    bad_strings++;
                if (units_due.size() == 0) begin
                    $error("unexpected word: code_unit %h terminator %b malformed %b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    fail_count++;
                end else begin
                    want = units_due.pop_front();
                    if (m_axis_tdata !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.terminator) begin
                        $error("terminator: expected %b, got %b", want.terminator, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.malformed) begin
                        $error("malformed: expected %b, got %b", want.malformed, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                         idle_cycles, units_due.size());
                $display("tb_utf8_to_ucs2_stream_decoder_core: errors");
                $finish;
            end
        end
    end

    initial begin
        // Reset value of the limit first, then the limit at zero and at one.
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h00, 1'b0, 1, unit_word(16'h0000), NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h7F, 1'b1, 2, unit_word(16'h007F), TERM_OK));
        dir_rows.push_back(mk_row(ROW_PREDICT, 16'hC2, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_PREDICT, 16'hA9, 1'b1, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_PREDICT, 16'hEF, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_PREDICT, 16'hBF, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_PREDICT, 16'hBF, 1'b1, 0, NO_WORD, NO_WORD));
        // Stray continuation, then the rest of the string is dropped silently.
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h80, 1'b0, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h41, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h42, 1'b1, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hFF, 1'b1, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hF0, 1'b0, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h41, 1'b1, 0, NO_WORD, NO_WORD));
        // Wrong continuation byte.
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hC3, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h41, 1'b0, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h00, 1'b1, 0, NO_WORD, NO_WORD));
        // Sequences cut short by the final byte.
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hE2, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h82, 1'b1, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hDF, 1'b1, 1, TERM_BAD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_SET_LIMIT, 16'd0, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h41, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hC3, 1'b1, 1, TERM_OK, NO_WORD));
        dir_rows.push_back(mk_row(ROW_SET_LIMIT, 16'd1, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h41, 1'b0, 1, unit_word(16'h0041), NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'hFF, 1'b0, 0, NO_WORD, NO_WORD));
        dir_rows.push_back(mk_row(ROW_TYPED, 16'h80, 1'b1, 1, TERM_OK, NO_WORD));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SET_LIMIT)
                set_limit(dir_rows[i].val);
            else
                send_byte(dir_rows[i].val[7:0], dir_rows[i].last,
                          dir_rows[i].kind == ROW_TYPED, dir_rows[i].n,
                          dir_rows[i].w0, dir_rows[i].w1);
        end

        run_phase(16'd65535, 400, 1'b1, 1'b0);
        run_phase(16'd3, 250, 1'b0, 1'b0);
        run_phase(16'd0, 40, 1'b0, 1'b0);
        run_phase(16'd1, 150, 1'b0, 1'b0);
        run_phase(16'd255, 400, 1'b0, 1'b1);
        run_phase(16'd7, 300, 1'b0, 1'b0);
        run_phase(16'($urandom_range(2, 20)), 400, 1'b0, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (units_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d bytes offered, %0d decoded, %0d words in %0d strings",
                 bytes_sent, bytes_taken, words_seen, strings_seen);
        $display("run: %0d malformed strings, %0d limit settings from 0 to 65535",
                 bad_strings, cap_writes);
        if (fail_count == 0)
            $display("tb_utf8_to_ucs2_stream_decoder_core: clean");
        else
            $display("tb_utf8_to_ucs2_stream_decoder_core: errors");
        $finish;
    end

endmodule
